// ===== rtl/bqr_pkg.sv =====
// Shared types and constants for the bounded queue with remove-by-value.
// No dependencies; every other file in rtl/ imports this package.
package bqr_pkg;

	localparam int DATA_W           = 32;
	localparam int OP_W             = 2;
	localparam int STAT_W           = 2;
	localparam int COUNT_OUT_W      = 3;
	localparam int DEFAULT_CAPACITY = 7;

	// Operation codes carried in the operation field.
	localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

	// Status codes reported with every result item.
	localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic signed [DATA_W-1:0] value;
	} bqr_in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] result_value;
		logic [COUNT_OUT_W-1:0]   entry_count;
	} bqr_out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT
	} bqr_state_t;

endpackage

// ===== rtl/bounded_queue_with_remove_core.sv =====
// Top level of the bounded FIFO queue with remove-by-value.
// Depends on bqr_pkg and instantiates bqr_store.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_ready | in_item  (operation, value)
//   out     | output    | out_valid/out_ready | out_item (status, result_value, entry_count)
//
// Enqueue, reports of full or empty, and the unused operation code are answered from the idle state.
// Dequeue and remove instead take one pass over the store through its single read port,
// searching up to the match and then shifting the later entries back.
// One item is worked on at a time; in_ready is high only between items and while the
// output register is free or being emptied. A stalled output holds the next item off.
// Reset clears the count and the control state; the store needs no clearing.
module bounded_queue_with_remove_core
	import bqr_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bqr_in_item_t  in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output bqr_out_item_t out_item
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	bqr_state_t state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  ptr_q, ptr_d;
	logic [OP_W-1:0]   op_q, op_d;
	logic [DATA_W-1:0] val_q, val_d;
	logic [DATA_W-1:0] res_q, res_d;
	logic              out_valid_q, out_valid_d;
	bqr_out_item_t     out_item_q, out_item_d;

	logic              mem_we;
	logic [CNT_W-1:0]  wr_idx;
	logic [DATA_W-1:0] wr_data;
	logic [CNT_W-1:0]  rd_idx;
	logic [IDX_W-1:0]  rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic [CNT_W-1:0]  ptr_inc;
	logic              hit;

	// Low three bits of a count, whatever the count width.
	function automatic logic [COUNT_OUT_W-1:0] low_count(input logic [CNT_W-1:0] c);
		logic [CNT_W+COUNT_OUT_W-1:0] e;
		e = {{COUNT_OUT_W{1'b0}}, c};
		return e[COUNT_OUT_W-1:0];
	endfunction

	// Addresses at or past the capacity only occur when the data is unused.
	assign rd_addr = (rd_idx < CAP_C) ? rd_idx[IDX_W-1:0] : '0;

	bqr_store #(
		.DEPTH (CAPACITY),
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (wr_idx[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign ptr_inc = ptr_q + 1'b1;
	assign hit     = (op_q == OP_DEQUEUE) || (rd_data == val_q);

	// Next state, store accesses and result loading.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		ptr_d       = ptr_q;
		op_d        = op_q;
		val_d       = val_q;
		res_d       = res_q;
		mem_we      = 1'b0;
		wr_idx      = ptr_q;
		wr_data     = rd_data;
		rd_idx      = '0;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		out_item_d  = out_item_q;

		unique case (state_q)
			S_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					op_d  = in_item.operation;
					val_d = in_item.value;
					ptr_d = '0;
					unique case (in_item.operation)
						OP_ENQUEUE: begin
							out_valid_d = 1'b1;
							if (count_q == CAP_C) begin
								out_item_d = '{STAT_FULL, '0, low_count(count_q)};
							end else begin
								mem_we     = 1'b1;
								wr_idx     = count_q;
								wr_data    = in_item.value;
								count_d    = count_q + 1'b1;
								out_item_d = '{STAT_DONE, in_item.value,
									low_count(count_q + 1'b1)};
							end
						end
						OP_DEQUEUE, OP_REMOVE: begin
							if (count_q == '0) begin
								out_valid_d = 1'b1;
								out_item_d  = '{STAT_EMPTY, '0, low_count(count_q)};
							end else begin
								state_d = S_SEARCH;
							end
						end
						default: begin
							out_valid_d = 1'b1;
							out_item_d  = '{STAT_DONE, '0, low_count(count_q)};
						end
					endcase
				end
			end

			// Data of entry ptr_q is on rd_data; the next entry is fetched meanwhile.
			S_SEARCH: begin
				rd_idx = ptr_inc;
				if (hit) begin
					res_d   = rd_data;
					state_d = S_SHIFT;
				end else if (ptr_inc < count_q) begin
					ptr_d = ptr_inc;
				end else begin
					out_valid_d = 1'b1;
					out_item_d  = '{STAT_NOT_FOUND, '0, low_count(count_q)};
					state_d     = S_IDLE;
				end
			end

			// Move entry ptr_q + 1 (on rd_data) down one place to close the gap.
			S_SHIFT: begin
				if (ptr_inc < count_q) begin
					mem_we  = 1'b1;
					wr_idx  = ptr_q;
					wr_data = rd_data;
					rd_idx  = ptr_inc + 1'b1;
					ptr_d   = ptr_inc;
				end else begin
					count_d     = count_q - 1'b1;
					out_valid_d = 1'b1;
					out_item_d  = '{STAT_DONE, res_q, low_count(count_q - 1'b1)};
					state_d     = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Working and payload registers.
	always_ff @(posedge clk) begin
		ptr_q      <= ptr_d;
		op_q       <= op_d;
		val_q      <= val_d;
		res_q      <= res_d;
		out_item_q <= out_item_d;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== rtl/bqr_store.sv =====
// Entry store of the queue: one write port and one read port, registered read data.
// Depends on bqr_pkg for the data width.
module bqr_store
	import bqr_pkg::*;
#(
	parameter int DEPTH = DEFAULT_CAPACITY,
	parameter int IDX_W = 3
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/bqr_checker.sv =====
// Port-level assertions for bounded_queue_with_remove_core and the bind that attaches them.
// Depends on bqr_pkg and on the top level's port names.
module bqr_checker
	import bqr_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input bqr_in_item_t  in_item,
	input logic          out_valid,
	input logic          out_ready,
	input bqr_out_item_t out_item
);

	localparam int CNT_W = $clog2(CAPACITY + 1) + COUNT_OUT_W;
	localparam logic [CNT_W-1:0] CAP_EXT = CNT_W'(CAPACITY);
	localparam logic [COUNT_OUT_W-1:0] CAP_LOW = CAP_EXT[COUNT_OUT_W-1:0];

	// A result item waiting on the output holds with its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output item changed while stalled");

	// No new item is taken while a stalled result occupies the output.
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");

	// Any status other than done carries a zero value.
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != STAT_DONE |-> out_item.result_value == '0)
		else $error("nonzero value with failing status");

	// A full report shows the queue at capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == STAT_FULL |-> out_item.entry_count == CAP_LOW)
		else $error("full reported below capacity");

	// An empty report shows no entries.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == STAT_EMPTY |-> out_item.entry_count == '0)
		else $error("empty reported with entries held");

endmodule

bind bounded_queue_with_remove_core bqr_checker #(.CAPACITY(CAPACITY)) u_bqr_checker (.*);

// ===== tb/bqr_queue_checker.sv =====
// Checker for the bounded queue with remove-by-value: it watches both channels,
// keeps a shadow copy of the queue and compares every result item with its prediction.
// Depends on bqr_pkg for the item types, operation codes and status codes.
module bqr_queue_checker
	import bqr_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  bqr_in_item_t  in_item,
	input  logic          out_valid,
	input  logic          out_ready,
	input  bqr_out_item_t out_item,
	output int            fail_count,
	output int            outstanding,
	output int            results_checked,
	output int            full_seen,
	output int            empty_seen,
	output int            not_found_seen
);

	// Shadow of the queue contents, oldest entry first.
	logic signed [DATA_W-1:0] held_words[$];
	// Results predicted but not yet seen on the output channel.
	bqr_out_item_t            awaited_results[$];
	int                       errors = 0;

	assign fail_count = errors;

	task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		$display("ERROR at %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// Applies one operation to the shadow queue and returns the result it should produce.
	function automatic bqr_out_item_t apply_queue_op(input bqr_in_item_t item);
		bqr_out_item_t res;
		int            hit;
		res.status       = STAT_DONE;
		res.result_value = '0;
		hit              = -1;
		case (item.operation)
			OP_ENQUEUE: begin
				if (held_words.size() >= CAPACITY) begin
					res.status = STAT_FULL;
				end else begin
					held_words.push_back(item.value);
					res.result_value = item.value;
				end
			end
			OP_DEQUEUE: begin
				if (held_words.size() == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					res.result_value = held_words.pop_front();
				end
			end
			OP_REMOVE: begin
				if (held_words.size() == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					// The oldest entry with all 32 bits equal is the one deleted.
					foreach (held_words[i]) begin
						if (hit < 0 && held_words[i] == item.value) begin
							hit = i;
						end
					end
					if (hit < 0) begin
						res.status = STAT_NOT_FOUND;
					end else begin
						held_words.delete(hit);
						res.result_value = item.value;
					end
				end
			end
			default: begin
				// The unused code changes nothing and reports done with a zero value.
			end
		endcase
		res.entry_count = COUNT_OUT_W'(held_words.size());
		return res;
	endfunction

	// Results are compared before new inputs are predicted, so an item accepted at
	// the same edge can never be matched against its own prediction.
	always @(posedge clk or negedge arst_n) begin
		bqr_out_item_t want;
		if (!arst_n) begin
			held_words.delete();
			awaited_results.delete();
			outstanding     <= 0;
			results_checked <= 0;
			full_seen       <= 0;
			empty_seen      <= 0;
			not_found_seen  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch("result item with no item outstanding", out_item.result_value,
						'0);
				end else begin
					want = awaited_results.pop_front();
					if (out_item.status !== want.status) begin
						flag_mismatch("status", DATA_W'(out_item.status), DATA_W'(want.status));
					end
					if (out_item.result_value !== want.result_value) begin
						flag_mismatch("result_value", out_item.result_value, want.result_value);
					end
					if (out_item.entry_count !== want.entry_count) begin
						flag_mismatch("entry_count", DATA_W'(out_item.entry_count),
							DATA_W'(want.entry_count));
					end
					case (want.status)
						STAT_FULL:      full_seen <= full_seen + 1;
						STAT_EMPTY:     empty_seen <= empty_seen + 1;
						STAT_NOT_FOUND: not_found_seen <= not_found_seen + 1;
						default: ;
					endcase
				end
				results_checked <= results_checked + 1;
			end
			if (in_valid && in_ready) begin
				awaited_results.push_back(apply_queue_op(in_item));
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Top of the testbench for bounded_queue_with_remove_core: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on bqr_pkg and bqr_queue_checker.
module tb;
	import bqr_pkg::*;

	// The fourth operation code has no name in the package; the block must ignore it.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1425;
	localparam int LONG_HOLD    = 120;
	localparam int STALL_LIMIT  = 2000;
	localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	bqr_in_item_t  in_item;
	logic          out_valid;
	logic          out_ready;
	bqr_out_item_t out_item;

	int fail_count;
	int outstanding;
	int results_checked;
	int full_seen;
	int empty_seen;
	int not_found_seen;

	int  ops_sent[4];
	int  burst_left;
	int  quiet_cycles;
	bit  hold_req;
	logic signed [DATA_W-1:0] recent_values[8];
	int  recent_idx;

	bounded_queue_with_remove_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	bqr_queue_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.results_checked(results_checked),
		.full_seen(full_seen),
		.empty_seen(empty_seen),
		.not_found_seen(not_found_seen)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: ends the run when no item moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("bounded_queue_with_remove_core: mismatch");
				$finish;
			end
		end
	end

	// Receiver: switches among four stall patterns chosen at random, and holds off for a
	// long stretch whenever the stimulus asks for it.
	initial begin
		int phase_cycle;
		int mode;
		out_ready   = 1'b0;
		phase_cycle = 0;
		mode        = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (phase_cycle % 64 == 0) begin
					mode = $urandom_range(0, 3);
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (phase_cycle % 3 != 0);
				endcase
				phase_cycle++;
			end
		end
	end

	// Drives idle cycles on the input channel with junk on the payload.
	task automatic idle_input(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
			in_item.operation <= OP_W'($urandom());
			in_item.value <= $urandom();
		end
	endtask

	// Offers one item and waits until it is accepted; then maybe inserts a gap.
	task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
		@(negedge clk);
		in_valid <= 1'b1;
		in_item.operation <= op;
		in_item.value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ops_sent[op]++;
		if (op == OP_ENQUEUE) begin
			recent_values[recent_idx] = val;
			recent_idx = (recent_idx + 1) % 8;
		end
		burst_left--;
		if (burst_left <= 0) begin
			if ($urandom_range(0, 3) != 0) begin
				idle_input($urandom_range(1, 8));
			end
			burst_left = $urandom_range(1, 16);
		end
	endtask

	// Stops offering items until every predicted result has arrived.
	task automatic drain_queue_results();
		idle_input(1);
		while (outstanding != 0) @(negedge clk);
	endtask

	// Values favor recent enqueues and a tiny range so that removes often hit.
	function automatic logic signed [DATA_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			return recent_values[$urandom_range(0, 7)];
		end else if (roll < 60) begin
			return DATA_W'($urandom_range(0, 8)) - 4;
		end
		return $urandom();
	endfunction

	// Operation mix leans toward filling or toward draining by phase.
	function automatic logic [OP_W-1:0] pick_op(input bit filling);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			return OP_UNUSED;
		end
		if (filling) begin
			if (roll < 65) return OP_ENQUEUE;
			if (roll < 80) return OP_DEQUEUE;
			return OP_REMOVE;
		end
		if (roll < 30) return OP_ENQUEUE;
		if (roll < 62) return OP_DEQUEUE;
		return OP_REMOVE;
	endfunction

	// Stimulus and verdict.
	initial begin
		bit filling;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_item    = '0;
		hold_req   = 1'b0;
		burst_left = 4;
		recent_idx = 0;
		filling    = 1'b1;
		foreach (recent_values[i]) recent_values[i] = $urandom();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: empty-queue reports, the unused code, extreme values,
		// a full queue, a missing value, and removes at middle, tail and head.
		send_item(OP_DEQUEUE, 32'sd0);
		send_item(OP_REMOVE, 32'sd5);
		send_item(OP_UNUSED, MOST_NEG);
		send_item(OP_ENQUEUE, MOST_NEG);
		send_item(OP_ENQUEUE, MOST_POS);
		send_item(OP_ENQUEUE, 32'sd0);
		send_item(OP_ENQUEUE, -32'sd1);
		send_item(OP_ENQUEUE, 32'sd1);
		send_item(OP_ENQUEUE, -32'sd1);
		send_item(OP_ENQUEUE, 32'sd42);
		send_item(OP_ENQUEUE, 32'sd9);
		send_item(OP_UNUSED, -32'sd1);
		send_item(OP_REMOVE, 32'sd123);
		// Of the two equal entries, the older one must go.
		send_item(OP_REMOVE, -32'sd1);
		send_item(OP_REMOVE, 32'sd42);
		send_item(OP_REMOVE, MOST_NEG);
		send_item(OP_DEQUEUE, MOST_POS);
		send_item(OP_DEQUEUE, 32'sd7);
		send_item(OP_REMOVE, 32'shaaaa_aaaa);
		send_item(OP_DEQUEUE, 32'sd0);
		send_item(OP_DEQUEUE, 32'sd0);
		send_item(OP_DEQUEUE, 32'sd0);
		drain_queue_results();

		// Random part.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				filling = ~filling;
			end
			if (n == 60 || n == 900) begin
				// Long receiver hold while items keep coming, so the block backs up.
				hold_req = 1'b1;
			end
			if (n == 500 || n == 1200) begin
				drain_queue_results();
			end
			if (n >= 300 && n < 360) begin
				// A stretch with no gaps on the input side.
				burst_left = 100;
			end
			send_item(pick_op(filling), pick_value());
		end
		idle_input(1);

		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("items sent: %0d enqueue, %0d dequeue, %0d remove, %0d unused code",
			ops_sent[OP_ENQUEUE], ops_sent[OP_DEQUEUE], ops_sent[OP_REMOVE],
			ops_sent[OP_UNUSED]);
		$display("results checked: %0d (full %0d, empty %0d, not found %0d), errors %0d",
			results_checked, full_seen, empty_seen, not_found_seen, fail_count);
		if (fail_count == 0) begin
			$display("bounded_queue_with_remove_core: match");
		end else begin
			$display("bounded_queue_with_remove_core: mismatch");
		end
		$finish;
	end

endmodule
